>>> design/kmpoc_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the KMP occurrence counter.
// Used by kmpoc_cell, kmpoc_chain and kmp_occurrence_counter; no dependencies.
package kmpoc_pkg;

   localparam int PATTERN_MAX = 1024;
   localparam int COUNT_WIDTH = 20;
   localparam int CHAR_W      = 8;
   localparam int OUT_COUNT_W = 20;
   localparam int LOAD_W      = $clog2(PATTERN_MAX + 1);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // opcode of an input item
   localparam logic OP_PATTERN = 1'b0;
   localparam logic OP_TEXT    = 1'b1;

   typedef logic [CHAR_W-1:0] char_type;

   // control broadcast to every cell of the row
   typedef struct packed {
      logic shift;   // take a pattern byte from the left neighbor
      logic start;   // first byte of a new pattern load
      logic clear;   // drop all partial matches
      logic scan;    // advance partial matches with the text byte
   } cell_ctrl_type;

endpackage

>>> design/kmpoc_cell.sv
`timescale 1ns / 1ps
// One cell of the matcher row: holds one pattern byte, a start marker and
// the partial-match flag for the prefix that ends at this byte. Uses kmpoc_pkg.
module kmpoc_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  kmpoc_pkg::cell_ctrl_type ctrl,
   input  kmpoc_pkg::char_type    text_char,
   input  kmpoc_pkg::char_type    pat_in,
   input  logic                   first_in,
   input  logic                   flag_in,
   output kmpoc_pkg::char_type    pat_out,
   output logic                   first_out,
   output logic                   flag_out,
   output logic                   hit_out
);
   import kmpoc_pkg::*;

   char_type pat_ff;
   logic     first_ff;
   logic     first_in_d;
   logic     flag_ff;
   logic     flag_in_d;
   logic     active;

   // the cell holding the pattern's first byte always has an open prefix
   assign active  = first_ff | flag_in;
   assign hit_out = active & (pat_ff == text_char);

   always_comb begin
      first_in_d = first_ff;
      if (ctrl.shift) begin
         first_in_d = first_in;
      end
      flag_in_d = flag_ff;
      if (ctrl.clear) begin
         flag_in_d = 1'b0;
      end else if (ctrl.scan) begin
         flag_in_d = hit_out;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         pat_ff <= pat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b0;
         flag_ff  <= 1'b0;
      end else begin
         first_ff <= first_in_d;
         flag_ff  <= flag_in_d;
      end
   end

   assign pat_out   = pat_ff;
   assign first_out = first_ff;
   assign flag_out  = flag_ff;

endmodule

>>> design/kmpoc_chain.sv
`timescale 1ns / 1ps
// Row of matcher cells. Pattern bytes shift in at cell 0 and move right;
// partial-match flags move left and reach cell 0 on a full match. Uses kmpoc_pkg.
module kmpoc_chain (
   input  logic                   clock,
   input  logic                   reset,
   input  kmpoc_pkg::cell_ctrl_type ctrl,
   input  kmpoc_pkg::char_type    char_value,
   output logic                   hit
);
   import kmpoc_pkg::*;

   char_type pat_link   [PATTERN_MAX];
   logic     first_link [PATTERN_MAX];
   logic     flag_link  [PATTERN_MAX];
   logic     hit_link   [PATTERN_MAX];

   for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
      char_type pat_src;
      logic     first_src;
      logic     flag_src;

      if (i == 0) begin : g_head
         assign pat_src   = char_value;
         assign first_src = ctrl.start;
      end else begin : g_body
         assign pat_src   = pat_link[i-1];
         // a new load drops the old start marker
         assign first_src = first_link[i-1] & ~ctrl.start;
      end

      if (i == PATTERN_MAX - 1) begin : g_tail
         assign flag_src = 1'b0;
      end else begin : g_inner
         assign flag_src = flag_link[i+1];
      end

      kmpoc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .text_char (char_value),
         .pat_in    (pat_src),
         .first_in  (first_src),
         .flag_in   (flag_src),
         .pat_out   (pat_link[i]),
         .first_out (first_link[i]),
         .flag_out  (flag_link[i]),
         .hit_out   (hit_link[i])
      );
   end

   // cell 0 holds the pattern's last byte
   assign hit = ctrl.scan & hit_link[0];

endmodule

>>> design/kmp_occurrence_counter.sv
`timescale 1ns / 1ps
// Top level of the KMP occurrence counter: item handshake, load bookkeeping,
// saturating count and result register. Uses kmpoc_pkg and kmpoc_chain.
//
// Input channel req_*: one byte per item. req_tuser is the opcode (pattern
// byte or text byte), req_tlast marks the final byte of a pattern or a text.
// Result channel rsp_*: exactly one result item per input item, in order.
// Pattern bytes shift into a row of 1024 cells; the last pattern byte arms
// the matcher and clears the count. Each text byte is compared in every cell
// at once and partial matches step one cell toward the pattern's end, so an
// item is resolved as it is accepted: rsp_tvalid rises in the cycle after
// acceptance, and one item per cycle is taken while results drain.
// The single result register sets that rate; a stalled receiver holds the
// result and stops new items only while the register is full and not taken.
// Reset clears the pattern, the count and the result register; text before
// any pattern reports no match. Pattern bytes beyond 1024 are dropped with
// status set. A text item marked last clears the count after its result.
module kmp_occurrence_counter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_value
   input  logic        req_tuser,   // [0] opcode
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [0] match_here, [20:1] match_count, [21] status
);
   import kmpoc_pkg::*;

   logic [LOAD_W-1:0]      load_index_ff, load_index_in;
   logic                   pat_ready_ff, pat_ready_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH-1:0] count_out;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   hit_ff, hit_in;
   logic [OUT_COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                   status_ff, status_in;

   logic          in_fire;
   logic          is_pattern;
   logic          store_full;
   logic          hit;
   cell_ctrl_type ctrl;

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign in_fire    = req_tvalid & req_tready;
   assign is_pattern = (req_tuser == OP_PATTERN);
   assign store_full = (load_index_ff == LOAD_W'(PATTERN_MAX));

   always_comb begin
      ctrl.shift = in_fire & is_pattern & ~store_full;
      ctrl.start = (load_index_ff == '0);
      ctrl.clear = in_fire & (is_pattern | req_tlast);
      ctrl.scan  = in_fire & ~is_pattern & pat_ready_ff;
   end

   kmpoc_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .char_value (req_tdata),
      .hit        (hit)
   );

   always_comb begin
      load_index_in = load_index_ff;
      pat_ready_in  = pat_ready_ff;
      count_in      = count_ff;
      count_out     = count_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      hit_in        = hit_ff;
      rsp_count_in  = rsp_count_ff;
      status_in     = status_ff;
      if (in_fire) begin
         rsp_valid_in = 1'b1;
         if (is_pattern) begin
            pat_ready_in = 1'b0;
            if (!store_full) begin
               load_index_in = load_index_ff + LOAD_W'(1);
            end
            if (req_tlast) begin
               load_index_in = '0;
               count_out     = '0;
               pat_ready_in  = 1'b1;
            end
            count_in  = count_out;
            hit_in    = 1'b0;
            status_in = store_full;
         end else begin
            if (hit && count_ff != COUNT_MAX) begin
               count_out = count_ff + COUNT_WIDTH'(1);
            end
            // end of text: report, then start over
            count_in  = req_tlast ? '0 : count_out;
            hit_in    = hit;
            status_in = 1'b0;
         end
         rsp_count_in = OUT_COUNT_W'(count_out);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_index_ff <= '0;
         pat_ready_ff  <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         load_index_ff <= load_index_in;
         pat_ready_ff  <= pat_ready_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff       <= hit_in;
      rsp_count_ff <= rsp_count_in;
      status_ff    <= status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, status_ff, rsp_count_ff, hit_ff};

endmodule
